@@ src/adcl_pkg.sv @@
// Shared types, character constants and command tables of the ASCII DDS command line parser.
// Used by the front classifier, the item queue, the back parser and the top level.
// Depends on nothing.
package adcl_pkg;

    // Characters recognized by the parser
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Saturation limits of a field
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [35:0] SAT_MAG = 36'h0_8000_0000;

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Number of argument slots in a result
    localparam int ARG_SLOTS = 4;

    typedef enum logic [1:0] {
        TK_CHAR,
        TK_EOL,
        TK_ABORT
    } t_kind;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_BLANK,
        CL_SIGN,
        CL_COMMA,
        CL_NUL,
        CL_OTHER
    } t_class;

    typedef struct packed {
        t_kind      kind;
        t_class     cls;
        logic [7:0] data;
    } t_token;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_SIN  = 3'd1,
        CMD_BPSK = 3'd2,
        CMD_FSK  = 3'd3,
        CMD_OSK  = 3'd4,
        CMD_AM   = 3'd5,
        CMD_RFSK = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_BLANK,
        PH_SIGN,
        PH_DIGIT
    } t_phase;

    // Result item, command in the lowest bits
    typedef struct packed {
        logic [31:0] arg_fourth;
        logic [31:0] arg_third;
        logic [31:0] arg_second;
        logic [31:0] arg_first;
        t_cmd        command;
    } t_result;

    function automatic t_class classify(logic [7:0] c);
        t_class cls;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CL_DIGIT;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
            cls = CL_BLANK;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            cls = CL_SIGN;
        end else if (c == CH_COMMA) begin
            cls = CL_COMMA;
        end else if (c == CH_NUL) begin
            cls = CL_NUL;
        end else begin
            cls = CL_OTHER;
        end
        return cls;
    endfunction

    // Command selected by the first character of a line
    function automatic t_cmd first_cmd(logic [7:0] c);
        t_cmd cmd;
        case (c)
            "s":     cmd = CMD_SIN;
            "b":     cmd = CMD_BPSK;
            "f":     cmd = CMD_FSK;
            "o":     cmd = CMD_OSK;
            "a":     cmd = CMD_AM;
            "r":     cmd = CMD_RFSK;
            default: cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

    // Character at position k of a command's prefix
    function automatic logic [7:0] prefix_char(t_cmd cmd, logic [2:0] k);
        logic [4:0][7:0] txt;
        logic [7:0]      ch;
        case (cmd)
            CMD_SIN:  txt = {8'h00, ",", "n", "i", "s"};
            CMD_BPSK: txt = {",", "k", "s", "p", "b"};
            CMD_FSK:  txt = {8'h00, ",", "k", "s", "f"};
            CMD_OSK:  txt = {8'h00, ",", "k", "s", "o"};
            CMD_AM:   txt = {8'h00, 8'h00, ",", "m", "a"};
            CMD_RFSK: txt = {",", "k", "s", "f", "r"};
            default:  txt = '0;
        endcase
        case (k)
            3'd0:    ch = txt[0];
            3'd1:    ch = txt[1];
            3'd2:    ch = txt[2];
            3'd3:    ch = txt[3];
            3'd4:    ch = txt[4];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] prefix_len(t_cmd cmd);
        logic [2:0] len;
        case (cmd)
            CMD_SIN:  len = 3'd4;
            CMD_BPSK: len = 3'd5;
            CMD_FSK:  len = 3'd4;
            CMD_OSK:  len = 3'd4;
            CMD_AM:   len = 3'd3;
            CMD_RFSK: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] field_count(t_cmd cmd);
        logic [2:0] cnt;
        case (cmd)
            CMD_SIN:  cnt = 3'd2;
            CMD_BPSK: cnt = 3'd2;
            CMD_FSK:  cnt = 3'd2;
            CMD_OSK:  cnt = 3'd1;
            CMD_AM:   cnt = 3'd1;
            CMD_RFSK: cnt = 3'd4;
            default:  cnt = 3'd0;
        endcase
        return cnt;
    endfunction

    function automatic logic [31:0] value_mask(t_cmd cmd);
        logic [31:0] mask;
        case (cmd)
            CMD_BPSK: mask = 32'h0000_FFFF;
            CMD_OSK:  mask = 32'h0000_00FF;
            CMD_AM:   mask = 32'h0000_FFFF;
            default:  mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

@@ src/adcl_front.sv @@
// Front end: counts the bytes of a line, spots line ends and overlong lines, classifies bytes.
// Depends on adcl_pkg.
module adcl_front #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data,
    input  logic                i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output adcl_pkg::t_token    o_token
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             at_limit;
    logic             is_eol;

    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && !i_q_full;
    assign at_limit = (r_count == CNT_W'(LINE_CAPACITY - 1));
    assign is_eol   = (i_data == adcl_pkg::CH_CR) || (i_data == adcl_pkg::CH_LF);

    always_comb begin
        o_token.data = i_data;
        o_token.cls  = adcl_pkg::classify(i_data);
        if (at_limit) begin
            o_token.kind = adcl_pkg::TK_ABORT;
        end else if (is_eol) begin
            o_token.kind = adcl_pkg::TK_EOL;
        end else begin
            o_token.kind = adcl_pkg::TK_CHAR;
        end
    end

    // Restart the count on a line end or when a full line is dropped
    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (at_limit || is_eol) begin
                n_count = '0;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

@@ src/adcl_queue.sv @@
// Short item queue between the front classifier and the back parser.
// Depends on adcl_pkg.
module adcl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  adcl_pkg::t_token    i_token,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output adcl_pkg::t_token    o_token
);

    adcl_pkg::t_token                r_mem [adcl_pkg::QUEUE_DEPTH];
    logic [adcl_pkg::QPTR_W-1:0]     r_wptr;
    logic [adcl_pkg::QPTR_W-1:0]     r_rptr;
    logic [adcl_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == adcl_pkg::QCNT_W'(adcl_pkg::QUEUE_DEPTH));
    assign o_token = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + adcl_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + adcl_pkg::QPTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + adcl_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - adcl_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/adcl_back.sv @@
// Back end: prefix matching, decimal field parsing and the registered result stage.
// Depends on adcl_pkg.
module adcl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  adcl_pkg::t_token    i_token,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output adcl_pkg::t_result   o_result
);

    adcl_pkg::t_cmd                                 r_cmd;
    adcl_pkg::t_cmd                                 n_cmd;
    logic [2:0]                                     r_k;
    logic [2:0]                                     n_k;
    logic [1:0]                                     r_fnum;
    logic [1:0]                                     n_fnum;
    adcl_pkg::t_phase                               r_phase;
    adcl_pkg::t_phase                               n_phase;
    logic                                           r_neg;
    logic                                           n_neg;
    logic [adcl_pkg::ARG_SLOTS-1:0][31:0]           r_val;
    logic [adcl_pkg::ARG_SLOTS-1:0][31:0]           n_val;
    logic                                           r_rej;
    logic                                           n_rej;
    logic                                           r_ended;
    logic                                           n_ended;
    logic                                           r_out_valid;
    logic                                           n_out_valid;
    adcl_pkg::t_result                              r_out;
    adcl_pkg::t_result                              n_out;

    logic                                           clr_line;
    logic [31:0]                                    mag;
    logic [31:0]                                    fin_val;
    logic [35:0]                                    prod;
    logic                                           in_fields;
    logic                                           fields_ok;
    logic [adcl_pkg::ARG_SLOTS-1:0][31:0]           args;
    adcl_pkg::t_cmd                                 start_cmd;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Current field value, closed as it would be at a comma or line end
    assign mag     = r_val[r_fnum];
    assign fin_val = r_neg ? (32'd0 - mag) : ((mag > adcl_pkg::SAT_POS) ? adcl_pkg::SAT_POS : mag);
    assign prod    = ({4'd0, mag} << 3) + ({4'd0, mag} << 1)
                   + {32'd0, i_token.data[3:0]};
    assign start_cmd = adcl_pkg::first_cmd(i_token.data);

    assign in_fields = (r_cmd != adcl_pkg::CMD_NONE) && (r_k == adcl_pkg::prefix_len(r_cmd));
    assign fields_ok = !r_rej && in_fields
                     && (({1'b0, r_fnum} + 3'd1) == adcl_pkg::field_count(r_cmd))
                     && (r_phase != adcl_pkg::PH_BLANK) && (r_phase != adcl_pkg::PH_SIGN);

    always_comb begin
        for (int j = 0; j < adcl_pkg::ARG_SLOTS; j++) begin
            if (j < int'(r_fnum)) begin
                args[j] = r_val[j] & adcl_pkg::value_mask(r_cmd);
            end else if (j == int'(r_fnum)) begin
                args[j] = fin_val & adcl_pkg::value_mask(r_cmd);
            end else begin
                args[j] = '0;
            end
        end
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_k         = r_k;
        n_fnum      = r_fnum;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_val       = r_val;
        n_rej       = r_rej;
        n_ended     = r_ended;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        clr_line    = 1'b0;

        if (o_pop) begin
            case (i_token.kind)
                adcl_pkg::TK_ABORT: begin
                    clr_line = 1'b1;
                end
                adcl_pkg::TK_EOL: begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (fields_ok) begin
                        n_out.command    = r_cmd;
                        n_out.arg_first  = args[0];
                        n_out.arg_second = args[1];
                        n_out.arg_third  = args[2];
                        n_out.arg_fourth = args[3];
                    end
                    clr_line = 1'b1;
                end
                adcl_pkg::TK_CHAR: begin
                    if (!r_ended && !r_rej) begin
                        if (i_token.cls == adcl_pkg::CL_NUL) begin
                            n_ended = 1'b1;
                        end else if (r_cmd == adcl_pkg::CMD_NONE) begin
                            n_cmd = start_cmd;
                            n_k   = 3'd1;
                            if (start_cmd == adcl_pkg::CMD_NONE) begin
                                n_k   = 3'd0;
                                n_rej = 1'b1;
                            end
                        end else if (!in_fields) begin
                            if (adcl_pkg::prefix_char(r_cmd, r_k) == i_token.data) begin
                                n_k = r_k + 3'd1;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end else begin
                            case (i_token.cls)
                                adcl_pkg::CL_DIGIT: begin
                                    n_val[r_fnum] = (prod > adcl_pkg::SAT_MAG)
                                                  ? adcl_pkg::SAT_MAG[31:0] : prod[31:0];
                                    n_phase = adcl_pkg::PH_DIGIT;
                                end
                                adcl_pkg::CL_BLANK: begin
                                    if (r_phase == adcl_pkg::PH_EMPTY
                                        || r_phase == adcl_pkg::PH_BLANK) begin
                                        n_phase = adcl_pkg::PH_BLANK;
                                    end else begin
                                        n_rej = 1'b1;
                                    end
                                end
                                adcl_pkg::CL_SIGN: begin
                                    if (r_phase == adcl_pkg::PH_EMPTY
                                        || r_phase == adcl_pkg::PH_BLANK) begin
                                        n_phase = adcl_pkg::PH_SIGN;
                                        n_neg   = (i_token.data == adcl_pkg::CH_MINUS);
                                    end else begin
                                        n_rej = 1'b1;
                                    end
                                end
                                adcl_pkg::CL_COMMA: begin
                                    // close the field only if another one may follow
                                    if ((({1'b0, r_fnum} + 3'd1) < adcl_pkg::field_count(r_cmd))
                                        && r_phase != adcl_pkg::PH_BLANK
                                        && r_phase != adcl_pkg::PH_SIGN) begin
                                        n_val[r_fnum] = fin_val;
                                        n_fnum        = r_fnum + 2'd1;
                                        n_phase       = adcl_pkg::PH_EMPTY;
                                        n_neg         = 1'b0;
                                    end else begin
                                        n_rej = 1'b1;
                                    end
                                end
                                default: begin
                                    n_rej = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end

        if (clr_line) begin
            n_cmd   = adcl_pkg::CMD_NONE;
            n_k     = 3'd0;
            n_fnum  = 2'd0;
            n_phase = adcl_pkg::PH_EMPTY;
            n_neg   = 1'b0;
            n_val   = '0;
            n_rej   = 1'b0;
            n_ended = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= adcl_pkg::CMD_NONE;
            r_k         <= 3'd0;
            r_fnum      <= 2'd0;
            r_phase     <= adcl_pkg::PH_EMPTY;
            r_neg       <= 1'b0;
            r_val       <= '0;
            r_rej       <= 1'b0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd       <= n_cmd;
            r_k         <= n_k;
            r_fnum      <= n_fnum;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_val       <= n_val;
            r_rej       <= n_rej;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    a_none_has_no_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.command == adcl_pkg::CMD_NONE) |->
        (r_out.arg_first == '0 && r_out.arg_second == '0
         && r_out.arg_third == '0 && r_out.arg_fourth == '0))
        else $error("malformed line result carries argument bits");

    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != adcl_pkg::CMD_NONE) |->
        (r_k != 3'd0 && r_k <= adcl_pkg::prefix_len(r_cmd)))
        else $error("prefix position outside the command's prefix");

    a_extra_args_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.command != adcl_pkg::CMD_RFSK) |->
        (r_out.arg_third == '0 && r_out.arg_fourth == '0))
        else $error("third or fourth argument set for a short command");

    a_field_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fnum != 2'd0) |->
        (in_fields && ({1'b0, r_fnum} < adcl_pkg::field_count(r_cmd))))
        else $error("field index beyond the command's field count");
`endif

endmodule

@@ src/ascii_dds_command_line_parser.sv @@
// A line-end byte accepted from the slave side is held in the queue and then registered into the
//   result by the back parser before its result item shows on the master side.
// Throughput: one byte per cycle while the queue has room; the back parser handles one queued
//   byte a cycle. A result waiting on the master side stalls only the back; the four-entry
//   queue keeps accepting bytes until it fills.
// Reset (synchronous, active low) empties the queue, drops any pending result and starts a
//   fresh line with all field values at zero.
module ascii_dds_command_line_parser #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave side
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,    // [7:0] rx_byte
    // master side
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [135:0]  o_m_tdata     // [2:0] command, [34:3] arg_first, [66:35] arg_second,
                                        // [98:67] arg_third, [130:99] arg_fourth, rest zero
);

    // Front to queue
    logic                 front_push;
    adcl_pkg::t_token     front_token;
    logic                 q_full;

    // Queue to back
    logic                 q_valid;
    logic                 back_pop;
    adcl_pkg::t_token     q_token;

    adcl_pkg::t_result    result;

    // Count line bytes, mark line ends and overlong lines, classify each byte
    adcl_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_data   (i_s_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (front_push),
        .o_token  (front_token)
    );

    // Decouple byte intake from result delivery
    adcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_token (front_token),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_token (q_token)
    );

    // Match prefixes, parse fields, emit one result per line end
    adcl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_token     (q_token),
        .o_pop       (back_pop),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_result    (result)
    );

    // Pad the 131-bit result to whole bytes
    assign o_m_tdata = {5'd0, result};

endmodule

@@ tb/ascii_dds_command_line_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ascii_dds_command_line_parser: streams command-line bytes in,
// predicts each line's parsed command and fields, and checks every result item in order.
// Depends on adcl_pkg and the ascii_dds_command_line_parser top level.
module ascii_dds_command_line_parser_tb;

    localparam int LINE_CAP    = 128;
    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 6;
    // receiver hold-off window, counted by the receiver itself
    localparam int HOLD_FROM   = 400;
    localparam int HOLD_TO     = 650;
    // window with no idling on either side
    localparam int CALM_FROM   = 900;
    localparam int CALM_TO     = 1200;
    localparam int DRAIN_WAIT  = 20;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic [7:0]   in_byte = 8'h00;
    logic         out_ready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [135:0] o_m_tdata;

    ascii_dds_command_line_parser #(
        .LINE_CAPACITY(LINE_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (in_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (in_byte),      // [7:0] rx_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (out_ready),
        .o_m_tdata  (o_m_tdata)     // [2:0] command, [34:3] arg_first, [66:35] arg_second,
                                    // [98:67] arg_third, [130:99] arg_fourth, rest zero
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus bookkeeping and line predictor state
    // ------------------------------------------------------------------
    logic [7:0]          byte_q [$];       // bytes waiting for the driver
    adcl_pkg::t_result   parsed_q [$];     // parsed lines still owed by the block
    int                  bytes_queued = 0;
    int                  bytes_taken = 0;
    int                  errors = 0;
    int                  cyc = 0;
    int                  hold_cyc = 0;
    logic                in_fire = 1'b0;
    logic                calm;

    // current line as the parser sees it
    int                  ln_bytes;
    adcl_pkg::t_cmd      pfx_cmd;
    int                  pfx_k;
    int                  fld_idx;
    adcl_pkg::t_phase    fld_phase;
    bit                  fld_neg;
    logic [31:0]         fld_val [4];
    bit                  ln_bad;
    bit                  ln_nul;

    // line under construction for the random part
    logic [7:0]  lbuf [0:299];
    int          llen;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    function automatic string cmd_text(adcl_pkg::t_cmd c);
        case (c)
            adcl_pkg::CMD_SIN:  return "sin,";
            adcl_pkg::CMD_BPSK: return "bpsk,";
            adcl_pkg::CMD_FSK:  return "fsk,";
            adcl_pkg::CMD_OSK:  return "osk,";
            adcl_pkg::CMD_AM:   return "am,";
            adcl_pkg::CMD_RFSK: return "rfsk,";
            default:            return "";
        endcase
    endfunction

    function automatic int nfields(adcl_pkg::t_cmd c);
        case (c)
            adcl_pkg::CMD_OSK, adcl_pkg::CMD_AM: return 1;
            adcl_pkg::CMD_RFSK:                  return 4;
            adcl_pkg::CMD_NONE:                  return 0;
            default:                             return 2;
        endcase
    endfunction

    function automatic logic [31:0] arg_mask(adcl_pkg::t_cmd c);
        case (c)
            adcl_pkg::CMD_BPSK, adcl_pkg::CMD_AM: return 32'h0000_FFFF;
            adcl_pkg::CMD_OSK:                    return 32'h0000_00FF;
            default:                              return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void new_line();
        ln_bytes  = 0;
        pfx_cmd   = adcl_pkg::CMD_NONE;
        pfx_k     = 0;
        fld_idx   = 0;
        fld_phase = adcl_pkg::PH_EMPTY;
        fld_neg   = 1'b0;
        for (int i = 0; i < 4; i++) fld_val[i] = 32'd0;
        ln_bad    = 1'b0;
        ln_nul    = 1'b0;
    endfunction

    // Close the open field: apply sign or clamp to the positive limit.
    // A field holding only blanks or only a sign is malformed.
    function automatic bit close_field();
        if (fld_phase == adcl_pkg::PH_BLANK || fld_phase == adcl_pkg::PH_SIGN) return 1'b0;
        if (fld_neg)
            fld_val[fld_idx] = 32'd0 - fld_val[fld_idx];
        else if (fld_val[fld_idx] > adcl_pkg::SAT_POS)
            fld_val[fld_idx] = adcl_pkg::SAT_POS;
        return 1'b1;
    endfunction

    // Advance the line parser by one accepted byte; push a parsed line at each line end.
    task automatic parse_byte(logic [7:0] c);
        adcl_pkg::t_result r;
        string             txt;
        logic [63:0]       m;
        int                nf;
        logic [31:0]       mask;
        // a full line drops this byte, whatever it is, and starts over
        if (ln_bytes >= LINE_CAP - 1) begin
            new_line();
            return;
        end
        if (c == adcl_pkg::CH_CR || c == adcl_pkg::CH_LF) begin
            r = '0;
            txt = cmd_text(pfx_cmd);
            nf = nfields(pfx_cmd);
            mask = arg_mask(pfx_cmd);
            if (!ln_bad && pfx_cmd != adcl_pkg::CMD_NONE && pfx_k == txt.len()
                && fld_idx + 1 == nf) begin
                if (close_field()) begin
                    r.command   = pfx_cmd;
                    r.arg_first = fld_val[0] & mask;
                    if (nf > 1) r.arg_second = fld_val[1] & mask;
                    if (nf > 2) begin
                        r.arg_third  = fld_val[2] & mask;
                        r.arg_fourth = fld_val[3] & mask;
                    end
                end
            end
            parsed_q.push_back(r);
            new_line();
            return;
        end
        ln_bytes++;
        if (ln_nul || ln_bad) return;
        // a NUL ends the content; later bytes only count toward capacity
        if (c == adcl_pkg::CH_NUL) begin
            ln_nul = 1'b1;
            return;
        end
        if (pfx_cmd == adcl_pkg::CMD_NONE) begin
            for (int i = 1; i <= 6; i++) begin
                txt = cmd_text(adcl_pkg::t_cmd'(i));
                if (txt[0] == c) begin
                    pfx_cmd = adcl_pkg::t_cmd'(i);
                    pfx_k   = 1;
                    return;
                end
            end
            ln_bad = 1'b1;
            return;
        end
        txt = cmd_text(pfx_cmd);
        if (pfx_k < txt.len()) begin
            if (txt[pfx_k] == c) pfx_k++;
            else ln_bad = 1'b1;
            return;
        end
        // inside the comma-separated fields
        if (c >= adcl_pkg::CH_ZERO && c <= adcl_pkg::CH_NINE) begin
            m = 64'(fld_val[fld_idx]);
            m = m * 64'd10 + 64'(c - adcl_pkg::CH_ZERO);
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            fld_val[fld_idx] = m[31:0];
            fld_phase = adcl_pkg::PH_DIGIT;
        end else if (c == adcl_pkg::CH_SPACE || c == adcl_pkg::CH_TAB
                     || c == adcl_pkg::CH_VT || c == adcl_pkg::CH_FF) begin
            if (fld_phase == adcl_pkg::PH_EMPTY || fld_phase == adcl_pkg::PH_BLANK)
                fld_phase = adcl_pkg::PH_BLANK;
            else ln_bad = 1'b1;
        end else if (c == adcl_pkg::CH_PLUS || c == adcl_pkg::CH_MINUS) begin
            if (fld_phase == adcl_pkg::PH_EMPTY || fld_phase == adcl_pkg::PH_BLANK) begin
                fld_phase = adcl_pkg::PH_SIGN;
                fld_neg   = (c == adcl_pkg::CH_MINUS);
            end else begin
                ln_bad = 1'b1;
            end
        end else if (c == adcl_pkg::CH_COMMA && fld_idx + 1 < nfields(pfx_cmd)) begin
            if (!close_field()) begin
                ln_bad = 1'b1;
            end else begin
                fld_idx++;
                fld_phase = adcl_pkg::PH_EMPTY;
                fld_neg   = 1'b0;
            end
        end else begin
            ln_bad = 1'b1;
        end
    endtask

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare one result item with the oldest parsed line.
    task automatic check_parsed(adcl_pkg::t_result got);
        adcl_pkg::t_result want;
        if (parsed_q.size() == 0) begin
            $display("%0t: result expected none, got %h", $time, got);
            errors++;
            return;
        end
        want = parsed_q.pop_front();
        cmp_field("command", 32'(want.command), 32'(got.command));
        cmp_field("arg_first", want.arg_first, got.arg_first);
        cmp_field("arg_second", want.arg_second, got.arg_second);
        cmp_field("arg_third", want.arg_third, got.arg_third);
        cmp_field("arg_fourth", want.arg_fourth, got.arg_fourth);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_item(logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_item(s[i]);
    endtask

    task automatic lput(logic [7:0] b);
        lbuf[llen] = b;
        llen++;
    endtask

    task automatic lput_text(string s);
        for (int i = 0; i < s.len(); i++) lput(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return adcl_pkg::CH_SPACE;
            1:       return adcl_pkg::CH_TAB;
            2:       return adcl_pkg::CH_VT;
            default: return adcl_pkg::CH_FF;
        endcase
    endfunction

    // Append one field: mostly well formed, sometimes empty, lone sign,
    // lone blank or a trailing blank.
    task automatic lput_field();
        int form;
        form = int'($urandom_range(19));
        if (form == 0) return;
        if (form == 1) begin
            lput($urandom_range(1) ? adcl_pkg::CH_MINUS : adcl_pkg::CH_PLUS);
            return;
        end
        if (form == 2) begin
            lput(pick_blank());
            return;
        end
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) lput(pick_blank());
        if ($urandom_range(2) == 0)
            lput($urandom_range(1) ? adcl_pkg::CH_MINUS : adcl_pkg::CH_PLUS);
        case (form % 5)
            0: lput_text($sformatf("%0d", $urandom_range(999)));
            1: lput_text($sformatf("%0d", $urandom()));
            // long digit strings hit saturation
            2: repeat ($urandom_range(10, 13))
                   lput(8'(adcl_pkg::CH_ZERO + $urandom_range(9)));
            // land right on the signed 32-bit limits
            3: lput_text($sformatf("%0d", 32'h7FFF_FFFF + $urandom_range(2)));
            default: begin
                lput(adcl_pkg::CH_ZERO);
                lput_text($sformatf("%0d", $urandom_range(65535)));
            end
        endcase
        if (form == 3) lput(pick_blank());
    endtask

    // Build one line in lbuf and queue it: mostly command lines with random
    // fields, some damaged, plus noise and lines that overrun the capacity.
    task automatic gen_line();
        int             kind;
        int             nf;
        int             pos;
        adcl_pkg::t_cmd cmd;
        llen = 0;
        kind = int'($urandom_range(99));
        if (kind < 8) begin
            repeat ($urandom_range(1, 8)) lput(8'($urandom_range(255)));
        end else if (kind < 11) begin
            // blank padding walks the line across the capacity boundary
            lput_text("am,");
            repeat ($urandom_range(120, 136)) lput(pick_blank());
            lput(8'(adcl_pkg::CH_ZERO + $urandom_range(9)));
        end else begin
            cmd = adcl_pkg::t_cmd'($urandom_range(1, 6));
            lput_text(cmd_text(cmd));
            nf = nfields(cmd);
            case ($urandom_range(9))
                0:       nf++;
                1:       nf--;
                default: ;
            endcase
            for (int i = 0; i < nf; i++) begin
                if (i != 0) lput(adcl_pkg::CH_COMMA);
                lput_field();
            end
            if ($urandom_range(5) == 0) begin
                pos = int'($urandom_range(llen - 1));
                case ($urandom_range(3))
                    0:       lbuf[pos] = adcl_pkg::CH_NUL;
                    1:       lbuf[pos] = 8'($urandom_range(255));
                    2:       lbuf[pos] = adcl_pkg::CH_COMMA;
                    default: lbuf[pos] = pick_blank();
                endcase
            end
        end
        lput($urandom_range(1) ? adcl_pkg::CH_CR : adcl_pkg::CH_LF);
        for (int i = 0; i < llen; i++) push_item(lbuf[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next byte at the falling edge, hold it until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_byte  <= byte_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off that fills the block's queue
    always @(negedge i_clk) begin
        hold_cyc <= hold_cyc + 1;
        if (hold_cyc >= HOLD_FROM && hold_cyc < HOLD_TO)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: check results and feed accepted bytes to the predictor at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && out_ready) check_parsed(o_m_tdata[130:0]);
            if (in_valid && o_s_tready) begin
                parse_byte(in_byte);
                bytes_taken++;
            end
            in_fire <= in_valid && o_s_tready;
        end else begin
            in_fire <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed lines, pause, random lines, drain
    // ------------------------------------------------------------------
    initial begin
        new_line();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: negative field truncated to 16 bits, empty field,
        // unknown command, NUL ending the content, top-bit byte, empty line
        push_text("am,-7");
        push_item(adcl_pkg::CH_LF);
        push_text("osk,");
        push_item(adcl_pkg::CH_CR);
        push_text("x");
        push_item(adcl_pkg::CH_LF);
        push_text("am,9");
        push_item(adcl_pkg::CH_NUL);
        push_text("x");
        push_item(adcl_pkg::CH_LF);
        push_item(8'hFF);
        push_item(adcl_pkg::CH_CR);
        push_item(adcl_pkg::CH_LF);

        // hold the sender until every parsed line has come back
        while (bytes_taken != bytes_queued || parsed_q.size() != 0) @(negedge i_clk);

        while (bytes_queued < ITEM_TARGET) gen_line();

        while (bytes_taken != bytes_queued || parsed_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
